[src/ssof_pkg.sv]
package ssof_pkg;

  localparam int MAX_SQUARES = 64;

  // Storage and arithmetic widths
  localparam int COORD_W = 16;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int AREA_W  = DIST_W + 2;
  localparam int ADDR_W  = (MAX_SQUARES > 1) ? $clog2(MAX_SQUARES) : 1;
  localparam int COUNT_W = $clog2(MAX_SQUARES + 1);
  localparam int SUM_W   = AREA_W + COUNT_W;
  localparam int A10_W   = AREA_W + 4;
  localparam int DIM_W   = 13;
  localparam int IMG_W   = 2 * DIM_W;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_KEPT          = 2'd0;
  localparam logic [1:0] VERDICT_TOO_LARGE     = 2'd1;
  localparam logic [1:0] VERDICT_OUT_OF_BOUNDS = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] middle_x;
    logic [COORD_W-1:0] middle_y;
    logic [COORD_W-1:0] corner0_x;
    logic [COORD_W-1:0] corner0_y;
    logic [COORD_W-1:0] corner1_x;
    logic [COORD_W-1:0] corner1_y;
    logic [COORD_W-1:0] corner2_x;
    logic [COORD_W-1:0] corner2_y;
    logic [COORD_W-1:0] corner3_x;
    logic [COORD_W-1:0] corner3_y;
    logic               last_square;
  } item_t;

  typedef struct packed {
    logic [5:0] square_index;
    logic [1:0] verdict;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic       load;
    logic       square;
    logic [1:0] corner;
    logic       accum;
    logic       accum_first;
    logic       store;
    logic       scan_read;
    logic       clear_frame;
  } dp_cmd_t;

  typedef struct packed {
    logic last_square;
    logic scan_end;
    logic pipe_empty;
  } dp_status_t;

endpackage

[src/square_size_outlier_filter_unit.sv]
// Square size outlier filter. Raise start with one square on item while busy
// is low; busy then stays high until the square is in the frame store, and
// the next square is taken only once busy is low again. ST_SQUARE passes the
// corners in turn through the single pair of 16-bit squaring multipliers,
// ST_ACCUM_LAST folds the last distance into the maximum and ST_STORE writes
// the area into the frame store. After the square marked last_square the
// block stays busy while it reads the store back one entry a cycle (at most
// 64 stored squares), and emits one verdict per stored square on consecutive
// cycles, each shown for exactly one cycle with result_valid high; the
// receiver cannot stall them. Squares beyond 64 in a frame are ignored. Write
// image_width and image_height only while busy is low and no verdict is due.
module square_size_outlier_filter_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  ssof_pkg::item_t            item,
  input  logic                       config_write,
  input  logic                       config_index,
  input  logic [ssof_pkg::DIM_W-1:0] config_data,
  output logic                       result_valid,
  output ssof_pkg::result_t          result
);

  ssof_pkg::dp_cmd_t    cmd;
  ssof_pkg::dp_status_t status;

  ssof_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ssof_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .config_write (config_write),
    .config_index (config_index),
    .config_data  (config_data),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[src/ssof_controller.sv]
module ssof_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ssof_pkg::dp_status_t status,
  output ssof_pkg::dp_cmd_t   cmd,
  output logic                busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM_LAST,
    ST_STORE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t     state;
  logic [1:0] corner;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      corner <= 2'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          corner <= 2'd0;
          if (start) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          corner <= corner + 2'd1;
          if (corner == 2'd3) begin
            state <= ST_ACCUM_LAST;
          end
        end
        ST_ACCUM_LAST: begin
          state <= ST_STORE;
        end
        ST_STORE: begin
          state <= status.last_square ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          if (status.scan_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (status.pipe_empty) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.load        = (state == ST_IDLE) && start;
    cmd.square      = (state == ST_SQUARE);
    cmd.corner      = corner;
    // squares of a corner are ready in the cycle after they are started
    cmd.accum       = ((state == ST_SQUARE) && (corner != 2'd0)) || (state == ST_ACCUM_LAST);
    cmd.accum_first = (state == ST_SQUARE) && (corner == 2'd1);
    cmd.store       = (state == ST_STORE);
    cmd.scan_read   = (state == ST_SCAN) && !status.scan_end;
    cmd.clear_frame = (state == ST_DRAIN) && status.pipe_empty;
  end

  assign busy = (state != ST_IDLE);

endmodule

[src/ssof_datapath.sv]
module ssof_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  ssof_pkg::dp_cmd_t             cmd,
  input  ssof_pkg::item_t               item,
  input  logic                          config_write,
  input  logic                          config_index,
  input  logic [ssof_pkg::DIM_W-1:0]    config_data,
  output ssof_pkg::dp_status_t          status,
  output logic                          result_valid,
  output ssof_pkg::result_t             result
);

  // Configuration
  logic [ssof_pkg::DIM_W-1:0] image_width;
  logic [ssof_pkg::DIM_W-1:0] image_height;
  logic [ssof_pkg::IMG_W-1:0] image_area;

  // Area computation
  ssof_pkg::item_t              item_q;
  logic [ssof_pkg::COORD_W-1:0] sel_x;
  logic [ssof_pkg::COORD_W-1:0] sel_y;
  logic [ssof_pkg::COORD_W-1:0] dx;
  logic [ssof_pkg::COORD_W-1:0] dy;
  logic [ssof_pkg::SQ_W-1:0]    sq_x;
  logic [ssof_pkg::SQ_W-1:0]    sq_y;
  logic [ssof_pkg::DIST_W-1:0]  dist_sq;
  logic [ssof_pkg::DIST_W-1:0]  best;
  logic [ssof_pkg::AREA_W-1:0]  area;

  // Frame store
  logic [ssof_pkg::AREA_W-1:0]  area_mem [ssof_pkg::MAX_SQUARES];
  logic [ssof_pkg::SUM_W-1:0]   area_sum;
  logic [ssof_pkg::COUNT_W-1:0] square_count;
  logic [ssof_pkg::COUNT_W-1:0] scan_idx;
  logic                         frame_full;

  // Scan pipeline
  logic                         rd_valid;
  logic [ssof_pkg::AREA_W-1:0]  rd_area;
  logic [ssof_pkg::COUNT_W-1:0] rd_index;
  logic                         rd_last;
  logic                         prod_valid;
  logic [ssof_pkg::A10_W-1:0]   prod_a10;
  logic [ssof_pkg::SUM_W-1:0]   prod_an;
  logic [ssof_pkg::COUNT_W-1:0] prod_index;
  logic                         prod_last;
  logic                         too_large;
  logic                         above_mean;
  logic                         below_mean;
  logic [1:0]                   verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ssof_pkg::WIDTH_RESET;
      image_height <= ssof_pkg::HEIGHT_RESET;
    end else if (config_write) begin
      case (config_index)
        ssof_pkg::REG_IMAGE_WIDTH:  image_width  <= config_data;
        ssof_pkg::REG_IMAGE_HEIGHT: image_height <= config_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    image_area <= ssof_pkg::IMG_W'(image_width) * ssof_pkg::IMG_W'(image_height);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
  end

  always_comb begin
    case (cmd.corner)
      2'd0: begin
        sel_x = item_q.corner0_x;
        sel_y = item_q.corner0_y;
      end
      2'd1: begin
        sel_x = item_q.corner1_x;
        sel_y = item_q.corner1_y;
      end
      2'd2: begin
        sel_x = item_q.corner2_x;
        sel_y = item_q.corner2_y;
      end
      default: begin
        sel_x = item_q.corner3_x;
        sel_y = item_q.corner3_y;
      end
    endcase
  end

  assign dx = (item_q.middle_x >= sel_x) ? item_q.middle_x - sel_x : sel_x - item_q.middle_x;
  assign dy = (item_q.middle_y >= sel_y) ? item_q.middle_y - sel_y : sel_y - item_q.middle_y;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_x <= ssof_pkg::SQ_W'(dx) * ssof_pkg::SQ_W'(dx);
      sq_y <= ssof_pkg::SQ_W'(dy) * ssof_pkg::SQ_W'(dy);
    end
  end

  assign dist_sq = ssof_pkg::DIST_W'(sq_x) + ssof_pkg::DIST_W'(sq_y);

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      if (cmd.accum_first || (dist_sq > best)) begin
        best <= dist_sq;
      end
    end
  end

  assign area       = ssof_pkg::AREA_W'({best, 1'b0});
  assign frame_full = (square_count == ssof_pkg::COUNT_W'(ssof_pkg::MAX_SQUARES));

  // Drop squares that arrive once the store is full
  always_ff @(posedge clk) begin
    if (cmd.store && !frame_full) begin
      area_mem[square_count[ssof_pkg::ADDR_W-1:0]] <= area;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_frame) begin
      area_sum     <= '0;
      square_count <= '0;
      scan_idx     <= '0;
    end else begin
      if (cmd.store && !frame_full) begin
        area_sum     <= area_sum + ssof_pkg::SUM_W'(area);
        square_count <= square_count + 1'b1;
      end
      if (cmd.scan_read) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_area  <= area_mem[scan_idx[ssof_pkg::ADDR_W-1:0]];
    rd_index <= scan_idx;
    rd_last  <= ((scan_idx + 1'b1) == square_count);
  end

  always_ff @(posedge clk) begin
    prod_a10   <= (ssof_pkg::A10_W'(rd_area) << 3) + (ssof_pkg::A10_W'(rd_area) << 1);
    prod_an    <= ssof_pkg::SUM_W'(rd_area) * ssof_pkg::SUM_W'(square_count);
    prod_index <= rd_index;
    prod_last  <= rd_last;
  end

  assign too_large  = prod_a10 > ssof_pkg::A10_W'({image_area, 8'd0});
  assign above_mean = {2'b00, prod_an} > {area_sum, 2'b00};
  assign below_mean = {prod_an, 2'b00} < {2'b00, area_sum};

  always_comb begin
    if (too_large) begin
      verdict = ssof_pkg::VERDICT_TOO_LARGE;
    end else if (above_mean || below_mean) begin
      verdict = ssof_pkg::VERDICT_OUT_OF_BOUNDS;
    end else begin
      verdict = ssof_pkg::VERDICT_KEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid     <= 1'b0;
      prod_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_valid     <= cmd.scan_read;
      prod_valid   <= rd_valid;
      result_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.square_index <= 6'(prod_index);
    result.verdict      <= verdict;
    result.last_result  <= prod_last;
  end

  assign status.last_square = item_q.last_square;
  assign status.scan_end    = (scan_idx == square_count);
  assign status.pipe_empty  = !rd_valid && !prod_valid;

endmodule

[src/ssof_checker.sv]
module ssof_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input ssof_pkg::item_t            item,
  input logic                       config_write,
  input logic                       config_index,
  input logic [ssof_pkg::DIM_W-1:0] config_data,
  input logic                       result_valid,
  input ssof_pkg::result_t          result
);

  // An accepted transaction keeps the block busy
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // Verdicts only come out of a frame that was still in progress
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("verdict outside a frame");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.verdict == ssof_pkg::VERDICT_KEPT ||
                      result.verdict == ssof_pkg::VERDICT_TOO_LARGE ||
                      result.verdict == ssof_pkg::VERDICT_OUT_OF_BOUNDS))
    else $error("undefined verdict code");

  // Verdicts of a frame stream back to back in index order
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_result |=>
      result_valid && (result.square_index == $past(result.square_index) + 6'd1))
    else $error("verdict stream broken or out of order");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_result |=> !result_valid)
    else $error("verdict after the last of the frame");

endmodule

bind square_size_outlier_filter_unit ssof_checker u_checker (.*);

[verif/tb_square_size_outlier_filter_unit.sv]
`timescale 1ns / 100ps

module tb_square_size_outlier_filter_unit;
  import ssof_pkg::*;

  localparam int IDLE_GAP_MAX  = 20;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 3000;
  localparam int REPORT_LIMIT  = 10;

  class verdict_scoreboard;
    bit [63:0]   img_width;
    bit [63:0]   img_height;
    bit [63:0]   frame_area[MAX_SQUARES];
    bit [63:0]   frame_sum;
    int unsigned frame_count;
    result_t     verdicts_due[$];
    int unsigned mismatches;

    function new();
      img_width   = 640;
      img_height  = 480;
      frame_sum   = 0;
      frame_count = 0;
      mismatches  = 0;
    endfunction

    function void set_image(bit [63:0] w, bit [63:0] h);
      img_width  = w;
      img_height = h;
    endfunction

    // Area is twice the largest squared centre-to-corner distance; image area is in Q.8.
    function void note_square(item_t sq);
      bit [63:0] px[4];
      bit [63:0] py[4];
      bit [63:0] mx, my, dx, dy, dist_sq, best, img_q8, a, n;
      result_t   want;
      mx = sq.middle_x;
      my = sq.middle_y;
      px[0] = sq.corner0_x; py[0] = sq.corner0_y;
      px[1] = sq.corner1_x; py[1] = sq.corner1_y;
      px[2] = sq.corner2_x; py[2] = sq.corner2_y;
      px[3] = sq.corner3_x; py[3] = sq.corner3_y;
      best = 0;
      for (int k = 0; k < 4; k++) begin
        dx = (mx >= px[k]) ? mx - px[k] : px[k] - mx;
        dy = (my >= py[k]) ? my - py[k] : py[k] - my;
        dist_sq = dx * dx + dy * dy;
        if (dist_sq > best) best = dist_sq;
      end
      // Drop squares beyond capacity; a last mark still closes the frame.
      if (frame_count < MAX_SQUARES) begin
        frame_area[frame_count] = best * 2;
        frame_sum += best * 2;
        frame_count++;
      end
      if (!sq.last_square) return;
      img_q8 = img_width * img_height * 256;
      n = frame_count;
      for (int unsigned i = 0; i < frame_count; i++) begin
        a = frame_area[i];
        want.square_index = 6'(i);
        if (a * 10 > img_q8)
          want.verdict = VERDICT_TOO_LARGE;
        else if (a * n > 4 * frame_sum || 4 * a * n < frame_sum)
          want.verdict = VERDICT_OUT_OF_BOUNDS;
        else
          want.verdict = VERDICT_KEPT;
        want.last_result = (i + 1 == frame_count);
        verdicts_due.push_back(want);
      end
      frame_sum   = 0;
      frame_count = 0;
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected verdict: idx %0d verdict %0d last %0d",
                   got.square_index, got.verdict, got.last_result);
        return;
      end
      want = verdicts_due.pop_front();
      if (got.square_index !== want.square_index || got.verdict !== want.verdict ||
          got.last_result !== want.last_result) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"verdict mismatch: expected idx %0d verdict %0d last %0d, ",
                    "got idx %0d verdict %0d last %0d"},
                   want.square_index, want.verdict, want.last_result,
                   got.square_index, got.verdict, got.last_result);
      end
    endfunction

    function int unsigned outstanding();
      return verdicts_due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  item_t             item = '0;
  logic              config_write = 1'b0;
  logic              config_index = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0]  config_data = '0;
  logic              result_valid;
  result_t           result;

  verdict_scoreboard frame_check = new();
  int unsigned       idle_pct = 0;
  int unsigned       stall_cycles = 0;

  square_size_outlier_filter_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .config_write (config_write),
    .config_index (config_index),
    .config_data  (config_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) frame_check.note_square(item);
      if (result_valid) frame_check.check_verdict(result);
      if ((start && !busy) || result_valid)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [15:0] clamp16(int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Corner k sits in its own quadrant at offset hk on both axes.
  function automatic item_t square_at(int mx, int my, int h0, int h1, int h2, int h3,
                                      bit last);
    item_t sq;
    sq.middle_x    = clamp16(mx);
    sq.middle_y    = clamp16(my);
    sq.corner0_x   = clamp16(mx + h0);
    sq.corner0_y   = clamp16(my + h0);
    sq.corner1_x   = clamp16(mx - h1);
    sq.corner1_y   = clamp16(my + h1);
    sq.corner2_x   = clamp16(mx - h2);
    sq.corner2_y   = clamp16(my - h2);
    sq.corner3_x   = clamp16(mx + h3);
    sq.corner3_y   = clamp16(my - h3);
    sq.last_square = last;
    return sq;
  endfunction

  // Hold start high between back-to-back transactions; lower it only to idle.
  task automatic send_square(item_t sq);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do begin
        @(posedge clk);
        gap++;
      end while (gap < IDLE_GAP_MAX && $urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    item  <= sq;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (busy || frame_check.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_image(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    config_write <= 1'b1;
    config_index <= REG_IMAGE_WIDTH;
    config_data  <= w;
    @(posedge clk);
    config_index <= REG_IMAGE_HEIGHT;
    config_data  <= h;
    @(posedge clk);
    config_write <= 1'b0;
    frame_check.set_image(w, h);
  endtask

  // Mostly squares of a common size with a few outliers, some pure noise.
  task automatic send_frame(int unsigned len);
    int unsigned base, h, sel;
    item_t       sq;
    base = (1 << $urandom_range(0, 13)) + $urandom_range(0, 15);
    for (int unsigned i = 0; i < len; i++) begin
      sel = $urandom_range(99);
      h = base;
      if (sel < 12) h = base / 8;
      else if (sel < 24) h = base * 6;
      if (sel >= 88) begin
        for (int k = 0; k < 5; k++) sq[32*k+1 +: 32] = $urandom;
        sq.last_square = (i == len - 1);
      end else begin
        sq = square_at($urandom_range(0, 65535), $urandom_range(0, 65535),
                       h + $urandom_range(0, h / 4), h + $urandom_range(0, h / 4),
                       h + $urandom_range(0, h / 4), h + $urandom_range(0, h / 4),
                       i == len - 1);
      end
      send_square(sq);
    end
  endtask

  initial begin
    item_t       sq;
    int unsigned sent;
    int unsigned len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single degenerate square: zero area is kept.
    sq = '0;
    sq.last_square = 1'b1;
    send_square(sq);

    // Mixed frame: each corner farthest in turn, a tiny and a big outlier,
    // and both full-range squares, which are too large.
    send_square(square_at(16000, 16000, 160, 160, 160, 160, 1'b0));
    send_square(square_at(20000, 9000, 100, 160, 120, 90, 1'b0));
    send_square(square_at(30000, 30000, 120, 130, 170, 110, 1'b0));
    send_square(square_at(40000, 12000, 150, 140, 130, 175, 1'b0));
    send_square(square_at(8000, 50000, 180, 150, 140, 120, 1'b0));
    send_square(square_at(5000, 5000, 8, 8, 8, 8, 1'b0));
    send_square(square_at(32768, 32768, 800, 800, 800, 800, 1'b0));
    sq = '1;
    sq.middle_x = '0;
    sq.middle_y = '0;
    sq.last_square = 1'b0;
    send_square(sq);
    sq = '0;
    sq.middle_x = 16'hFFFF;
    sq.middle_y = 16'hFFFF;
    sq.last_square = 1'b1;
    send_square(sq);

    // Large square among normal ones, below the image limit.
    for (int i = 0; i < 6; i++)
      send_square(square_at(10000 + 3000 * i, 20000, 160, 160, 160, 160, 1'b0));
    send_square(square_at(45000, 45000, 1000, 1000, 1000, 1000, 1'b1));

    // Zero-sized image: every nonzero area is too large.
    drain();
    write_image(13'd0, 13'h1FFF);
    send_square('0);
    send_square(square_at(1000, 1000, 4, 4, 4, 4, 1'b0));
    send_square(square_at(60000, 60000, 64, 64, 64, 64, 1'b1));

    for (int p = 0; p < 6; p++) begin
      idle_pct = (p < 2) ? 28 : (p < 4) ? 80 : 0;
      drain();
      case (p)
        0: write_image(13'd1, 13'd1);
        1: write_image(13'd4096, 13'd4096);
        2: write_image(13'h1FFF, 13'd1);
        5: write_image(13'd1, 13'd4096);
        default: write_image(DIM_W'($urandom_range(1, 4096)),
                             DIM_W'($urandom_range(1, 4096)));
      endcase
      sent = 0;
      if (p == 3) begin
        // Overfull frame: the tail, last mark included, is not stored.
        sent = $urandom_range(65, 70);
        send_frame(sent);
      end
      while (sent < 4) begin
        len = $urandom_range(1, 4);
        send_frame(len);
        sent += len;
      end
    end

    drain();
    if (frame_check.outstanding() != 0)
      $display("%0d verdicts never arrived", frame_check.outstanding());
    if (frame_check.mismatches == 0 && frame_check.outstanding() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
src/ssof_pkg.sv
src/ssof_controller.sv
src/ssof_datapath.sv
src/square_size_outlier_filter_unit.sv
src/ssof_checker.sv
verif/tb_square_size_outlier_filter_unit.sv
